// File: sv/io_expander_poll_sequencer_core_assert.svh
// Assertion macros shared by the poll sequencer RTL.
`ifndef IO_EXPANDER_POLL_SEQUENCER_CORE_ASSERT_SVH
`define IO_EXPANDER_POLL_SEQUENCER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define IOEPS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// A condition that implies another one in the same cycle.
`define IOEPS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that implies another one in the following cycle.
`define IOEPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ioeps_pkg.sv
// Types, constants and word builders for the I/O expander poll sequencer.
`default_nettype none

package ioeps_pkg;

   // Width of the internal consecutive error counter.
   localparam int COUNT_WIDTH = 8;

   // Transfer slots of the polling ring.
   localparam logic [2:0] SLOT_FIRST = 3'd0;
   localparam logic [2:0] SLOT_OUT0  = 3'd3;
   localparam logic [2:0] SLOT_LED   = 3'd5;
   localparam logic [2:0] SLOT_READ  = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PORT_CFG     = 2'd0;
   localparam logic [1:0] CSR_LED_CFG      = 2'd1;
   localparam logic [1:0] CSR_POWER_ENABLE = 2'd2;

   // Configuration register reset values.
   localparam logic [19:0] PORT_CFG_RESET     = 20'h80002;
   localparam logic [8:0]  LED_CFG_RESET      = 9'd282;
   localparam logic        POWER_ENABLE_RESET = 1'b1;

   // Bus addresses and expander registers.
   localparam logic [6:0] DEV_BASE   = 7'h20;
   localparam logic [6:0] DEV_IO     = 7'h22;
   localparam logic [2:0] REG_CONFIG = 3'h6;
   localparam logic [2:0] REG_OUTPUT = 3'h2;
   localparam logic [2:0] REG_INPUT  = 3'h1;
   localparam logic [1:0] LEN_WRITE  = 2'd2;
   localparam logic [1:0] LEN_READ   = 2'd1;

   // Device index of each expander within the config slots.
   localparam logic [1:0] DEV_IDX_LOW = 2'd0;
   localparam logic [1:0] DEV_IDX_MID = 2'd1;

   // Fixed input pins of the third expander.
   localparam logic [7:0] FIXED_INPUTS = 8'b00111000;

   // Port modes and their expander nibbles.
   localparam logic [1:0] MODE_UNSET = 2'd0;
   localparam logic [1:0] MODE_RS485 = 2'd1;
   localparam logic [1:0] MODE_RS422 = 2'd2;
   localparam logic [1:0] MODE_BOTH  = 2'd3;
   localparam logic [3:0] NIB_UNSET  = 4'b0000;
   localparam logic [3:0] NIB_RS485  = 4'b0001;
   localparam logic [3:0] NIB_RS422  = 4'b1110;
   localparam logic [3:0] NIB_BOTH   = 4'b0010;

   // LED modes.
   localparam logic [2:0] LED_OFF    = 3'd0;
   localparam logic [2:0] LED_SLOW   = 3'd2;
   localparam logic [2:0] LED_MEDIUM = 3'd3;
   localparam logic [2:0] LED_FAST   = 3'd4;

   typedef struct packed {
      logic [19:0] port_cfg;
      logic [8:0]  led_cfg;
      logic        power_enable;
   } cfg_type;

   typedef struct packed {
      logic [31:0] time_us;
      logic        link_busy;
      logic        link_error;
      logic [15:0] rx_word;
   } item_type;

   typedef struct packed {
      logic        issue_start;
      logic        issue_read;
      logic [1:0]  issue_length;
      logic [6:0]  issue_device;
      logic [2:0]  issue_register;
      logic [15:0] issue_tx_word;
      logic [2:0]  power_good;
      logic [7:0]  errors_in_row;
      logic [19:0] mode_enable_word;
   } result_type;

   // Expander direction nibble for one port mode.
   function automatic logic [3:0] port_nibble(input logic [1:0] mode);
      logic [3:0] nib;
      case (mode)
         MODE_RS485: nib = NIB_RS485;
         MODE_RS422: nib = NIB_RS422;
         MODE_BOTH:  nib = NIB_BOTH;
         MODE_UNSET: nib = NIB_UNSET;
         default:    nib = NIB_UNSET;
      endcase
      return nib;
   endfunction

   // Configuration word of one expander; the lowest port sits in the top nibble.
   function automatic logic [15:0] config_word(input logic [1:0] dev,
                                               input logic [19:0] modes);
      logic [15:0] word;
      case (dev)
         DEV_IDX_LOW: word = {port_nibble(modes[1:0]), port_nibble(modes[3:2]),
                              port_nibble(modes[5:4]), port_nibble(modes[7:6])};
         DEV_IDX_MID: word = {port_nibble(modes[9:8]), port_nibble(modes[11:10]),
                              port_nibble(modes[13:12]), port_nibble(modes[15:14])};
         default:     word = {FIXED_INPUTS, port_nibble(modes[17:16]),
                              port_nibble(modes[19:18])};
      endcase
      return word;
   endfunction

   // State of one LED from its mode and the microsecond time.
   function automatic logic led_state(input logic [2:0] mode, input logic [31:0] t);
      logic lit;
      case (mode)
         LED_OFF:    lit = 1'b0;
         LED_SLOW:   lit = t[21];
         LED_MEDIUM: lit = t[19];
         LED_FAST:   lit = t[17];
         default:    lit = 1'b1;
      endcase
      return lit;
   endfunction

   // Output word of the third expander: active-low LEDs and the power enable.
   function automatic logic [15:0] led_word(input logic [8:0] modes,
                                            input logic [31:0] t,
                                            input logic pwr);
      logic [2:0] lit;
      lit = {led_state(modes[8:6], t), led_state(modes[5:3], t),
             led_state(modes[2:0], t)};
      return {1'b0, pwr, 3'b000, ~lit, 8'h00};
   endfunction

   // Transceiver enable bits: RS485 ports low half, RS422 ports high half.
   function automatic logic [19:0] mode_word(input logic [19:0] modes);
      logic [19:0] word;
      word = '0;
      for (int p = 0; p < 10; p++) begin
         word[p]      = (modes[2*p +: 2] == MODE_RS485);
         word[p + 10] = (modes[2*p +: 2] == MODE_RS422);
      end
      return word;
   endfunction

endpackage

`default_nettype wire

// File: sv/ioeps_csr.sv
// Configuration registers of the poll sequencer.
`default_nettype none

module ioeps_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [19:0]       csr_wdata,
   output ioeps_pkg::cfg_type     cfg
);
   import ioeps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign write_en = csr_valid && csr_ready;

   // Decode the register index; unknown indexes leave everything alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            CSR_PORT_CFG:     cfg_in.port_cfg     = csr_wdata;
            CSR_LED_CFG:      cfg_in.led_cfg      = csr_wdata[8:0];
            CSR_POWER_ENABLE: cfg_in.power_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_cfg     <= PORT_CFG_RESET;
         cfg_ff.led_cfg      <= LED_CFG_RESET;
         cfg_ff.power_enable <= POWER_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/ioeps_seq.sv
// Slot ring, error counter and input word, with the per-beat decision logic.
`default_nettype none

`include "io_expander_poll_sequencer_core_assert.svh"

module ioeps_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  ioeps_pkg::item_type       item,
   input  ioeps_pkg::cfg_type        cfg,
   output ioeps_pkg::result_type     result
);
   import ioeps_pkg::*;

   logic [2:0]             slot_ff;
   logic [2:0]             slot_in;
   logic [COUNT_WIDTH-1:0] run_ff;
   logic [COUNT_WIDTH-1:0] run_in;
   logic [15:0]            word_ff;
   logic [15:0]            word_in;
   logic [31:0]            run_wide;
   result_type             res;

   // Next state and the transfer to issue for this beat.
   always_comb begin
      slot_in = slot_ff;
      run_in  = run_ff;
      word_in = word_ff;
      res     = '0;
      res.power_good       = {word_ff[14], word_ff[15], word_ff[13]};
      res.mode_enable_word = mode_word(cfg.port_cfg);
      if (!item.link_busy) begin
         if (item.link_error) begin
            // Retry the same slot; the counter sticks at all ones.
            if (run_ff != '1) begin
               run_in = run_ff + COUNT_WIDTH'(1);
            end
         end else begin
            if (slot_ff >= SLOT_READ) begin
               word_in = item.rx_word;
               slot_in = SLOT_FIRST;
            end else begin
               slot_in = slot_ff + 3'd1;
            end
            run_in = '0;
         end
         res.issue_start = 1'b1;
         if (slot_in >= SLOT_READ) begin
            res.issue_read     = 1'b1;
            res.issue_length   = LEN_READ;
            res.issue_device   = DEV_IO;
            res.issue_register = REG_INPUT;
         end else if (slot_in < SLOT_OUT0) begin
            res.issue_length   = LEN_WRITE;
            res.issue_device   = DEV_BASE + {5'b00000, slot_in[1:0]};
            res.issue_register = REG_CONFIG;
            res.issue_tx_word  = config_word(slot_in[1:0], cfg.port_cfg);
         end else begin
            res.issue_length   = LEN_WRITE;
            res.issue_device   = DEV_BASE + 7'(slot_in - SLOT_OUT0);
            res.issue_register = REG_OUTPUT;
            res.issue_tx_word  = (slot_in == SLOT_LED) ?
                                 led_word(cfg.led_cfg, item.time_us, cfg.power_enable) :
                                 16'h0000;
         end
      end
   end

   // Reported count is capped at eight bits.
   assign run_wide = 32'(run_in);

   always_comb begin
      result = res;
      result.errors_in_row = (run_wide > 32'd255) ? 8'hFF : run_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_FIRST;
         run_ff  <= '0;
         word_ff <= '0;
      end else if (step_en) begin
         slot_ff <= slot_in;
         run_ff  <= run_in;
         word_ff <= word_in;
      end
   end

   `IOEPS_ASSERT_ALWAYS(a_slot_in_ring, slot_ff <= SLOT_READ, "slot left the ring")
   `IOEPS_ASSERT_NEXT(a_success_clears, step_en && !item.link_busy && !item.link_error, run_ff == '0, "error count not cleared after success")
   `IOEPS_ASSERT_NEXT(a_hold_when_idle, !step_en || item.link_busy, $stable(slot_ff) && $stable(run_ff) && $stable(word_ff), "state moved without a beat")

endmodule

`default_nettype wire

// File: sv/io_expander_poll_sequencer_core.sv
// Top level of the I/O expander poll sequencer.
//
// Each beat on the req channel is one status sample of the I2C master: the
// microsecond time, busy and error flags and the last received word. For
// every beat exactly one rsp beat follows, saying whether a transfer is
// issued and which one (device, register, direction, length, write data),
// plus the power-good bits, the consecutive error count and the transceiver
// enable word. The ring runs through three config writes, three output
// writes and one input read, retrying a slot after an error.
// A beat accepted into the input register is decided on and registered into
// the rsp register. Throughput is one beat per cycle while rsp is not stalled;
// the decision is a single pass of logic between the input and rsp registers.
// When rsp_tready is low the rsp register holds its beat and one more req
// beat is still taken into the input register; after that req_tready drops.
// Synchronous reset empties both registers, restarts the ring at the first
// config write with a zero error count and zero input word, and loads the
// configuration defaults. The csr channel is always ready; write it only
// while no beat is in flight.
`default_nettype none

`include "io_expander_poll_sequencer_core_assert.svh"

module io_expander_poll_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [31:0] time_us, [32] link_busy, [33] link_error, [49:34] rx_word, rest zero
   input  wire logic [55:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] issue_start, [1] issue_read, [3:2] issue_length, [10:4] issue_device,
   // [13:11] issue_register, [29:14] issue_tx_word, [32:30] power_good,
   // [40:33] errors_in_row, [60:41] mode_enable_word, rest zero
   output      logic [63:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   import ioeps_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type step_result;
   cfg_type    cfg;
   logic       out_free;
   logic       step_en;
   logic       req_fire;

   assign csr_ready = 1'b1;

   ioeps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ioeps_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Handshake: the input register moves on whenever the rsp register is free.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = step_en ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.time_us    <= req_tdata[31:0];
         in_item_ff.link_busy  <= req_tdata[32];
         in_item_ff.link_error <= req_tdata[33];
         in_item_ff.rx_word    <= req_tdata[49:34];
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_ff.mode_enable_word,
                        out_ff.errors_in_row,
                        out_ff.power_good,
                        out_ff.issue_tx_word,
                        out_ff.issue_register,
                        out_ff.issue_device,
                        out_ff.issue_length,
                        out_ff.issue_read,
                        out_ff.issue_start};

   `IOEPS_ASSERT_IMPLIES(a_stall_means_full, !req_tready, in_valid_ff && out_valid_ff, "input stalled with a free register")
   `IOEPS_ASSERT_NEXT(a_step_fills_output, step_en, out_valid_ff, "decided beat lost")
   `IOEPS_ASSERT_NEXT(a_rsp_held, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled rsp beat changed")

endmodule

`default_nettype wire

// File: dv/tb_io_expander_poll_sequencer_core.sv
// Self-checking testbench for the I/O expander poll sequencer: directed and random master samples.
`timescale 1ns / 100ps

module tb_io_expander_poll_sequencer_core;
   import ioeps_pkg::*;

   // Spare register index that the block must ignore.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   // Quiet cycles after the last response before touching registers.
   localparam int SETTLE_CYCLES = 6;
   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   // Mismatches printed in full before only counting.
   localparam int REPORT_LIMIT = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   // [31:0] time_us, [32] link_busy, [33] link_error, [49:34] rx_word, rest zero
   logic [55:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] issue_start, [1] issue_read, [3:2] issue_length, [10:4] issue_device,
   // [13:11] issue_register, [29:14] issue_tx_word, [32:30] power_good,
   // [40:33] errors_in_row, [60:41] mode_enable_word, rest zero
   wire  [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_wdata = '0;

   // Master status samples waiting to be sent, and the transfers they should cause.
   item_type   sample_queue[$];
   result_type expected_issues[$];
   int         queued_total = 0;
   int         answered_total = 0;
   int         mismatch_count = 0;
   int         hang_count = 0;
   logic       calm = 1'b0;

   // Shadow of the sequencer state and its configuration.
   logic [2:0]             ring_slot;
   logic [COUNT_WIDTH-1:0] error_run;
   logic [15:0]            input_word;
   cfg_type                csr_shadow;

   io_expander_poll_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Direction nibble that an expander needs for one port mode.
   function automatic logic [3:0] expander_nibble(input logic [1:0] mode);
      case (mode)
         MODE_RS485: return NIB_RS485;
         MODE_RS422: return NIB_RS422;
         MODE_BOTH:  return NIB_BOTH;
         default:    return NIB_UNSET;
      endcase
   endfunction

   // Config word of expander dev; its lowest port lands in the top nibble.
   function automatic logic [15:0] expander_config_word(input logic [1:0] dev);
      logic [15:0] w;
      w = '0;
      if (dev == DEV_IDX_LOW || dev == DEV_IDX_MID) begin
         for (int p = 0; p < 4; p++)
            w[15 - 4*p -: 4] = expander_nibble(csr_shadow.port_cfg[2*(4*dev + p) +: 2]);
      end else begin
         w = {FIXED_INPUTS, expander_nibble(csr_shadow.port_cfg[17:16]),
              expander_nibble(csr_shadow.port_cfg[19:18])};
      end
      return w;
   endfunction

   // Output word of the third expander: LEDs are active low, power enable in bit 14.
   function automatic logic [15:0] led_output_word(input logic [31:0] t);
      logic [2:0]  lit;
      logic [15:0] w;
      for (int l = 0; l < 3; l++) begin
         case (csr_shadow.led_cfg[3*l +: 3])
            LED_OFF:    lit[l] = 1'b0;
            LED_SLOW:   lit[l] = t[21];
            LED_MEDIUM: lit[l] = t[19];
            LED_FAST:   lit[l] = t[17];
            default:    lit[l] = 1'b1;
         endcase
      end
      w = '0;
      w[10:8] = ~lit;
      w[14] = csr_shadow.power_enable;
      return w;
   endfunction

   // Transceiver enables: RS485 ports in the low ten bits, RS422 in the high ten.
   function automatic logic [19:0] transceiver_word();
      logic [19:0] w;
      w = '0;
      for (int p = 0; p < 10; p++) begin
         if (csr_shadow.port_cfg[2*p +: 2] == MODE_RS485) w[p] = 1'b1;
         if (csr_shadow.port_cfg[2*p +: 2] == MODE_RS422) w[p + 10] = 1'b1;
      end
      return w;
   endfunction

   // Advance the shadow ring by one sample and form the response it should produce.
   task automatic poll_step(input item_type s, output result_type r);
      r = '0;
      r.power_good = {input_word[14], input_word[15], input_word[13]};
      if (!s.link_busy) begin
         if (s.link_error) begin
            if (error_run != {COUNT_WIDTH{1'b1}}) error_run = error_run + 1'b1;
         end else begin
            if (ring_slot >= SLOT_READ) begin
               input_word = s.rx_word;
               ring_slot = SLOT_FIRST;
            end else begin
               ring_slot = ring_slot + 3'd1;
            end
            error_run = '0;
         end
         r.issue_start = 1'b1;
         if (ring_slot >= SLOT_READ) begin
            r.issue_read = 1'b1;
            r.issue_length = LEN_READ;
            r.issue_device = DEV_IO;
            r.issue_register = REG_INPUT;
         end else if (ring_slot < SLOT_OUT0) begin
            r.issue_length = LEN_WRITE;
            r.issue_device = DEV_BASE + ring_slot;
            r.issue_register = REG_CONFIG;
            r.issue_tx_word = expander_config_word(ring_slot[1:0]);
         end else begin
            r.issue_length = LEN_WRITE;
            r.issue_device = DEV_BASE + (ring_slot - SLOT_OUT0);
            r.issue_register = REG_OUTPUT;
            r.issue_tx_word = (ring_slot == SLOT_LED) ? led_output_word(s.time_us) : '0;
         end
      end
      r.errors_in_row = (error_run > 255) ? 8'd255 : error_run[7:0];
      r.mode_enable_word = transceiver_word();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) report_mismatch(what, want, got);
   endtask

   // Shadow state tracks register writes and every accepted sample.
   always @(posedge clock) begin : ring_predictor
      item_type   s;
      result_type r;
      if (reset) begin
         ring_slot = SLOT_FIRST;
         error_run = '0;
         input_word = '0;
         csr_shadow.port_cfg = PORT_CFG_RESET;
         csr_shadow.led_cfg = LED_CFG_RESET;
         csr_shadow.power_enable = POWER_ENABLE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PORT_CFG:     csr_shadow.port_cfg = csr_wdata;
               CSR_LED_CFG:      csr_shadow.led_cfg = csr_wdata[8:0];
               CSR_POWER_ENABLE: csr_shadow.power_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            s.time_us = req_tdata[31:0];
            s.link_busy = req_tdata[32];
            s.link_error = req_tdata[33];
            s.rx_word = req_tdata[49:34];
            poll_step(s, r);
            expected_issues = {expected_issues, r};
         end
      end
   end

   // Sample driver: a new beat goes out once the previous one is taken.
   always @(posedge clock) begin : sample_driver
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
            nxt = sample_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {6'b0, nxt.rx_word, nxt.link_error, nxt.link_busy, nxt.time_us};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor with random backpressure.
   always @(posedge clock) begin : issue_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 23);
         if (rsp_tvalid && rsp_tready) begin
            answered_total++;
            if (expected_issues.size() == 0) begin
               report_mismatch("response with nothing expected", '0, rsp_tdata[31:0]);
            end else begin
               want = expected_issues.pop_front();
               check_field("issue_start", want.issue_start, rsp_tdata[0]);
               check_field("issue_read", want.issue_read, rsp_tdata[1]);
               check_field("issue_length", want.issue_length, rsp_tdata[3:2]);
               check_field("issue_device", want.issue_device, rsp_tdata[10:4]);
               check_field("issue_register", want.issue_register, rsp_tdata[13:11]);
               check_field("issue_tx_word", want.issue_tx_word, rsp_tdata[29:14]);
               check_field("power_good", want.power_good, rsp_tdata[32:30]);
               check_field("errors_in_row", want.errors_in_row, rsp_tdata[40:33]);
               check_field("mode_enable_word", want.mode_enable_word, rsp_tdata[60:41]);
               check_field("padding", '0, rsp_tdata[63:61]);
            end
         end
      end
   end

   // Hang detection: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   task automatic push_sample(input logic [31:0] t, input logic busy, input logic err,
                              input logic [15:0] rx);
      item_type s;
      s.time_us = t;
      s.link_busy = busy;
      s.link_error = err;
      s.rx_word = rx;
      sample_queue = {sample_queue, s};
      queued_total++;
   endtask

   // Mostly realistic transfers (busy ticks, then a finish that may fail), some noise.
   task automatic push_traffic(input int n);
      int k;
      int busy_ticks;
      k = 0;
      while (k < n) begin
         if ($urandom_range(99) < 80) begin
            busy_ticks = $urandom_range(0, 3);
            repeat (busy_ticks)
               push_sample($urandom(), 1'b1, $urandom_range(1), $urandom_range(65535));
            push_sample($urandom(), 1'b0, $urandom_range(7) == 0, $urandom_range(65535));
            k += busy_ticks + 1;
         end else begin
            push_sample($urandom(), $urandom_range(1), $urandom_range(1),
                        $urandom_range(65535));
            k++;
         end
      end
   endtask

   // Wait until every sample has been answered, then let the block go quiet.
   task automatic settle();
      while (answered_total < queued_total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [19:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Busy masks everything, then errors retry slot zero and good samples walk the ring forward.
      push_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
      push_sample(32'h0, 1'b1, 1'b0, 16'h0000);
      push_sample(32'h0, 1'b0, 1'b1, 16'hFFFF);
      push_sample(32'h0, 1'b0, 1'b1, 16'h0000);
      repeat (4) push_sample(32'h0, 1'b0, 1'b0, 16'h0000);
      // LED slot with the blink time bits set, then cleared.
      push_sample(32'h002A_0000, 1'b0, 1'b0, 16'h0000);
      push_sample(32'h002A_0000, 1'b0, 1'b1, 16'h0000);
      push_sample(32'hFFD5_FFFF, 1'b0, 1'b1, 16'h0000);
      // Read slot: a failed read stores nothing, a good one stores the word.
      push_sample(32'h0, 1'b0, 1'b0, 16'hFFFF);
      push_sample(32'h0, 1'b1, 1'b0, 16'hFFFF);
      push_sample(32'h0, 1'b0, 1'b1, 16'hFFFF);
      push_sample(32'h0, 1'b0, 1'b0, 16'hFFFF);
      repeat (6) push_sample(32'h0, 1'b0, 1'b0, 16'h0000);
      push_sample(32'h0, 1'b0, 1'b0, 16'hA000);
      push_sample(32'h0, 1'b0, 1'b0, 16'h0000);
      push_traffic(150);
      settle();

      // All registers at their lowest values.
      write_csr(CSR_PORT_CFG, 20'h00000);
      write_csr(CSR_LED_CFG, 20'h00000);
      write_csr(CSR_POWER_ENABLE, 20'h00000);
      push_traffic(150);
      settle();

      // All registers at their highest values.
      write_csr(CSR_PORT_CFG, 20'hFFFFF);
      write_csr(CSR_LED_CFG, 20'h001FF);
      write_csr(CSR_POWER_ENABLE, 20'h00001);
      push_traffic(150);
      settle();

      // Every port mode in turn; the spare index must change nothing.
      write_csr(CSR_PORT_CFG, 20'h4E4E4);
      write_csr(CSR_LED_CFG, {11'd0, LED_FAST, 3'd5, 3'd1});
      write_csr(CSR_POWER_ENABLE, 20'h00000);
      write_csr(CSR_SPARE, 20'hFFFFF);
      push_traffic(150);
      settle();

      // Reversed port modes and the remaining LED codes, with no idling at all.
      write_csr(CSR_PORT_CFG, 20'hB1B1B);
      write_csr(CSR_LED_CFG, {11'd0, 3'd6, 3'd7, LED_MEDIUM});
      write_csr(CSR_POWER_ENABLE, 20'h00001);
      calm = 1'b1;
      push_traffic(200);
      settle();
      calm = 1'b0;

      // A long error run drives the counter into saturation.
      write_csr(CSR_PORT_CFG, $urandom_range(0, 20'hFFFFF));
      write_csr(CSR_LED_CFG, $urandom_range(0, 9'h1FF));
      repeat (270) push_sample($urandom(), 1'b0, 1'b1, $urandom_range(65535));
      push_sample($urandom(), 1'b1, 1'b1, $urandom_range(65535));
      push_sample($urandom(), 1'b0, 1'b1, $urandom_range(65535));
      push_sample($urandom(), 1'b0, 1'b0, $urandom_range(65535));
      push_traffic(100);
      settle();

      // Random settings.
      repeat (2) begin
         write_csr(CSR_PORT_CFG, $urandom_range(0, 20'hFFFFF));
         write_csr(CSR_LED_CFG, $urandom_range(0, 9'h1FF));
         write_csr(CSR_POWER_ENABLE, $urandom_range(1));
         push_traffic(100);
         settle();
      end

      if (expected_issues.size() != 0)
         report_mismatch("responses still outstanding", '0, expected_issues.size());
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/ioeps_pkg.sv
sv/ioeps_csr.sv
sv/ioeps_seq.sv
sv/io_expander_poll_sequencer_core.sv
dv/tb_io_expander_poll_sequencer_core.sv
